/* design/assert_macros.svh */
// Assertion macros used by the sorted ID list lookup sequencer (sil_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk outside reset.
`define SIL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition that must never be true outside reset.
`define SIL_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

/* design/sil_pkg.sv */
// Package for the sorted ID list lookup: constants, codes, states and shared types.
package sil_pkg;

  localparam int SIL_MAX_SNAPSHOTS = 64;
  localparam int MAX_ENTRIES       = 256;
  localparam int ENT_AW            = $clog2(MAX_ENTRIES);
  localparam int MOD_FRAC_BITS     = 16;
  localparam int MOD_W             = MOD_FRAC_BITS + 1;
  localparam int CNT_W             = 9;
  localparam int KEY_W             = 63;
  localparam int HALF_W            = 31;
  localparam int SNAP_W            = 6;
  localparam int CFG_W             = 7;
  localparam int PROBE_W           = 4;
  localparam int PROBE_MAX         = ENT_AW + 1;

  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 40;
  localparam int IN_TUSER_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_ENTRIES);
  localparam logic [MOD_W-1:0] MOD_ONE = MOD_W'(1) << MOD_FRAC_BITS;

  // configuration register indexes
  localparam logic CFG_REION_SNAP = 1'b0;
  localparam logic CFG_LOW_SNAP   = 1'b1;

  typedef enum logic [1:0] {
    CMD_SET_LEN = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_LOOKUP  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_META,
    ST_EVAL,
    ST_PROBE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] cnt;
  } meta_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [MOD_W-1:0] modifier;
  } entry_t;

endpackage

/* design/sorted_id_list_lookup.sv */
// Sorted ID list lookup: top level joining the sequencer and the two memories.
//
// Input stream (s_axis): one word per command. tuser carries the command
// (set list length, write entry, lookup); tdata carries the operands.
// Output stream (m_axis): exactly one result word per command word.
// Configuration: cfg_we/cfg_index/cfg_data write reion_snap (0) and
// low_snap (1); write only while no command is in flight.
// Timing: one command at a time. A searching lookup runs 1 to 9 probes for
// lists of up to 256 entries, with one read of the key memory per probe.
// Result tvalid is registered as the sequencer leaves its result state.
// A finished result sits in the output register; the next command is taken
// while it waits. If the receiver stalls, the following result is held in
// the sequencer and no further command is accepted until it moves out.
// Reset clears the list lengths, match counters and config registers at
// once; stored keys and modifiers are undefined until written.
module sorted_id_list_lookup
  import sil_pkg::*;
#(
  parameter int MAX_SNAPSHOTS = SIL_MAX_SNAPSHOTS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // snapshot, entry_index, entry_count, entry_key, entry_modifier,
  // tree_number, halo_number, count_match, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // found, found_index, modifier, match_total, all_matched, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int SNAP_AW = (MAX_SNAPSHOTS > 1) ? $clog2(MAX_SNAPSHOTS) : 1;

  logic [SNAP_AW-1:0]        meta_raddr;
  meta_t                     meta_rdata;
  logic                      meta_we;
  meta_t                     meta_wdata;
  logic                      ent_we;
  logic [SNAP_AW+ENT_AW-1:0] ent_waddr;
  entry_t                    ent_wdata;
  logic [SNAP_AW+ENT_AW-1:0] ent_raddr;
  entry_t                    ent_rdata;

  sil_ctrl #(
    .MAX_SNAPSHOTS (MAX_SNAPSHOTS),
    .SNAP_AW       (SNAP_AW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .meta_raddr    (meta_raddr),
    .meta_rdata    (meta_rdata),
    .meta_we       (meta_we),
    .meta_wdata    (meta_wdata),
    .ent_we        (ent_we),
    .ent_waddr     (ent_waddr),
    .ent_wdata     (ent_wdata),
    .ent_raddr     (ent_raddr),
    .ent_rdata     (ent_rdata)
  );

  sil_meta_mem #(
    .MAX_SNAPSHOTS (MAX_SNAPSHOTS),
    .SNAP_AW       (SNAP_AW)
  ) u_meta_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (meta_we),
    .waddr (meta_raddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  sil_entry_mem #(
    .MAX_SNAPSHOTS (MAX_SNAPSHOTS),
    .SNAP_AW       (SNAP_AW)
  ) u_entry_mem (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

endmodule

/* design/sil_meta_mem.sv */
// Per-snapshot list length and match counter memory with valid bits.
module sil_meta_mem
  import sil_pkg::*;
#(
  parameter int MAX_SNAPSHOTS = SIL_MAX_SNAPSHOTS,
  parameter int SNAP_AW       = (MAX_SNAPSHOTS > 1) ? $clog2(MAX_SNAPSHOTS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [SNAP_AW-1:0] waddr,
  input  meta_t              wdata,
  input  logic [SNAP_AW-1:0] raddr,
  output meta_t              rdata
);

  meta_t                    mem [MAX_SNAPSHOTS];
  logic [MAX_SNAPSHOTS-1:0] valid;
  meta_t                    rd_q;
  logic                     rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[raddr];
      if (we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // an entry never written reads as zero length, zero count
  assign rdata = rd_valid ? rd_q : '0;

endmodule

/* design/sil_entry_mem.sv */
// Key and modifier store, one row per snapshot and list position.
module sil_entry_mem
  import sil_pkg::*;
#(
  parameter int MAX_SNAPSHOTS = SIL_MAX_SNAPSHOTS,
  parameter int SNAP_AW       = (MAX_SNAPSHOTS > 1) ? $clog2(MAX_SNAPSHOTS) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [SNAP_AW+ENT_AW-1:0] waddr,
  input  entry_t                    wdata,
  input  logic [SNAP_AW+ENT_AW-1:0] raddr,
  output entry_t                    rdata
);

  localparam int DEPTH = MAX_SNAPSHOTS * MAX_ENTRIES;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

/* design/sil_ctrl.sv */
// Command sequencer: decodes words, runs the halving search and holds the result register.
`include "assert_macros.svh"

module sil_ctrl
  import sil_pkg::*;
#(
  parameter int MAX_SNAPSHOTS = SIL_MAX_SNAPSHOTS,
  parameter int SNAP_AW       = (MAX_SNAPSHOTS > 1) ? $clog2(MAX_SNAPSHOTS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic [IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output logic [SNAP_AW-1:0]        meta_raddr,
  input  meta_t                     meta_rdata,
  output logic                      meta_we,
  output meta_t                     meta_wdata,
  output logic                      ent_we,
  output logic [SNAP_AW+ENT_AW-1:0] ent_waddr,
  output entry_t                    ent_wdata,
  output logic [SNAP_AW+ENT_AW-1:0] ent_raddr,
  input  entry_t                    ent_rdata
);

  localparam int SNAP_XW = SNAP_AW + SNAP_W;

  state_t              state, state_next;
  logic [CFG_W-1:0]    reion_snap, low_snap;

  logic [1:0]          cmd_q;
  logic [SNAP_W-1:0]   snap_q;
  logic [ENT_AW-1:0]   eidx_q;
  logic [CNT_W-1:0]    ecnt_q;
  logic [KEY_W-1:0]    ekey_q;
  logic [MOD_W-1:0]    emod_q;
  logic [KEY_W-1:0]    id_q;
  logic                cm_q;
  logic [CNT_W-1:0]    len_q, cnt_q;
  logic [ENT_AW-1:0]   idx;
  logic [PROBE_W-1:0]  probe_c;

  logic                res_found, res_found_next;
  logic [ENT_AW-1:0]   res_pos, res_pos_next;
  logic [MOD_W-1:0]    res_mod, res_mod_next;
  logic [CNT_W-1:0]    res_total, res_total_next;
  logic                res_all, res_all_next;
  logic                res_load;

  logic [SNAP_XW-1:0]  snap_ext;
  logic                snap_ok;
  logic [SNAP_AW-1:0]  snap_addr;
  meta_t               cur;
  logic                reion_on, in_range, search_go;
  logic [CNT_W:0]      half;
  logic [ENT_AW-1:0]   init_idx;
  logic [CNT_W-1:0]    new_len;
  logic                hit, go_up, stop;
  logic [PROBE_W-1:0]  sh;
  logic [CNT_W:0]      mask, step, up_sum;
  logic [ENT_AW-1:0]   idx_up, idx_down, idx_next;
  logic [CNT_W-1:0]    cnt_inc;
  logic                out_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign snap_ext   = {{SNAP_AW{1'b0}}, snap_q};
  assign snap_ok    = snap_ext < SNAP_XW'(MAX_SNAPSHOTS);
  assign snap_addr  = snap_ext[SNAP_AW-1:0];
  assign meta_raddr = snap_addr;
  assign cur        = snap_ok ? meta_rdata : '0;

  assign reion_on  = reion_snap != low_snap;
  assign in_range  = {1'b0, snap_q} < reion_snap;
  assign search_go = (cmd_q == CMD_LOOKUP) && snap_ok && reion_on && in_range &&
                     (cur.len != '0);

  // first probe at ceil(n/2)-1
  assign half     = ({1'b0, cur.len} + (CNT_W+1)'(1)) >> 1;
  assign init_idx = ENT_AW'(half - (CNT_W+1)'(1));
  assign new_len  = (ecnt_q > LEN_MAX) ? LEN_MAX : ecnt_q;

  // probe compare and next position: step is ceil(n / 2^(c+1))
  assign hit     = ent_rdata.key == id_q;
  assign go_up   = id_q > ent_rdata.key;
  assign stop    = (len_q >> probe_c) == '0;
  assign sh      = probe_c + PROBE_W'(1);
  assign mask    = ((CNT_W+1)'(1) << sh) - (CNT_W+1)'(1);
  assign step    = ({1'b0, len_q} + mask) >> sh;
  assign up_sum  = {{(CNT_W+1-ENT_AW){1'b0}}, idx} + step;
  assign idx_up  = (up_sum >= {1'b0, len_q}) ? ENT_AW'(len_q - CNT_W'(1))
                                             : up_sum[ENT_AW-1:0];
  assign idx_down = (step > {{(CNT_W+1-ENT_AW){1'b0}}, idx}) ? '0
                  : ENT_AW'({{(CNT_W+1-ENT_AW){1'b0}}, idx} - step);
  assign idx_next = go_up ? idx_up : idx_down;
  assign cnt_inc  = (cnt_q != CNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_META;
      ST_META:  state_next = ST_EVAL;
      ST_EVAL:  state_next = search_go ? ST_PROBE : ST_DONE;
      ST_PROBE: if (hit || stop) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    meta_we        = 1'b0;
    meta_wdata     = '0;
    ent_we         = 1'b0;
    ent_waddr      = {snap_addr, eidx_q};
    ent_wdata      = '{key: ekey_q, modifier: emod_q};
    ent_raddr      = {snap_addr, idx_next};
    res_load       = 1'b0;
    res_found_next = 1'b0;
    res_pos_next   = '0;
    res_mod_next   = MOD_ONE;
    res_total_next = cur.cnt;
    res_all_next   = cur.cnt == cur.len;
    case (state)
      ST_EVAL: begin
        ent_raddr = {snap_addr, init_idx};
        if (!search_go) begin
          res_load = 1'b1;
          case (cmd_q)
            CMD_SET_LEN: begin
              if (snap_ok) begin
                meta_we        = 1'b1;
                meta_wdata     = '{len: new_len, cnt: '0};
                res_total_next = '0;
                res_all_next   = new_len == '0;
              end
            end
            CMD_WRITE: ent_we = snap_ok;
            default: ;
          endcase
        end
      end
      ST_PROBE: begin
        res_total_next = cnt_q;
        res_all_next   = cnt_q == len_q;
        if (hit) begin
          res_load       = 1'b1;
          res_found_next = 1'b1;
          res_pos_next   = idx;
          res_mod_next   = ent_rdata.modifier;
          if (cm_q) begin
            meta_we        = cnt_q != CNT_MAX;
            meta_wdata     = '{len: len_q, cnt: cnt_inc};
            res_total_next = cnt_inc;
            res_all_next   = cnt_inc == len_q;
          end
        end else if (stop) begin
          res_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      reion_snap    <= '0;
      low_snap      <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_REION_SNAP: reion_snap <= cfg_data;
          CFG_LOW_SNAP:   low_snap   <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q  <= s_axis_tuser;
      snap_q <= s_axis_tdata[5:0];
      eidx_q <= s_axis_tdata[13:6];
      ecnt_q <= s_axis_tdata[22:14];
      ekey_q <= s_axis_tdata[85:23];
      emod_q <= s_axis_tdata[102:86];
      // ID is tree << 32 | halo, bit 31 always clear
      id_q   <= {s_axis_tdata[133:103], 1'b0, s_axis_tdata[164:134]};
      cm_q   <= s_axis_tdata[165];
    end
    if (state == ST_EVAL) begin
      len_q   <= cur.len;
      cnt_q   <= cur.cnt;
      idx     <= init_idx;
      probe_c <= PROBE_W'(1);
    end else if (state == ST_PROBE) begin
      idx     <= idx_next;
      probe_c <= probe_c + PROBE_W'(1);
    end
    if (res_load) begin
      res_found <= res_found_next;
      res_pos   <= res_pos_next;
      res_mod   <= res_mod_next;
      res_total <= res_total_next;
      res_all   <= res_all_next;
    end
    if (state == ST_DONE && out_free) begin
      m_axis_tdata <= {{(OUT_TDATA_W-2-ENT_AW-MOD_W-CNT_W){1'b0}},
                       res_all, res_total, res_mod, res_pos, res_found};
    end
  end

  `SIL_ASSERT_NEVER(a_single_store_write, meta_we && ent_we, "both stores written at once")
  `SIL_ASSERT(a_probe_in_list, (state == ST_PROBE) |-> ({1'b0, idx} < len_q), "probe index past list end")
  `SIL_ASSERT(a_probe_bound, (state == ST_PROBE) |-> (probe_c <= PROBE_W'(PROBE_MAX)), "search ran too many probes")
  `SIL_ASSERT(a_done_exit, (state == ST_DONE) |=> (state == ST_DONE || state == ST_IDLE), "left result stage wrongly")

endmodule
